// ===== src/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants for the parallel drum controller
// Word layouts of the item and result channels, operation and device codes,
// and the reset values of the controller state.
// ----------------------------------------------------------------------------
package pdc_pkg;

    // Drum geometry. The track length is a power of two, so the position
    // wraps by plain overflow and a drum address reduces by a mask.
    localparam int unsigned TRACK_WORDS = 4096;
    localparam int unsigned POS_W       = $clog2(TRACK_WORDS);
    localparam int unsigned COUNT_W     = 13;
    localparam int unsigned WAIT_W      = 13;

    // Configuration port.
    localparam int unsigned ADDR_W = 1;
    localparam int unsigned DATA_W = 32;
    localparam logic [ADDR_W-1:0] REG_TICKS_PER_WORD = ADDR_W'(0);

    // Reset values.
    localparam logic [15:0]        TICKS_RESET   = 16'd85;
    localparam logic [3:0]         CHANNEL_RESET = 4'd5;
    localparam logic [COUNT_W-1:0] COUNT_RESET   = COUNT_W'(TRACK_WORDS);

    // Flags returned by a position read when a timing error was seen.
    localparam logic [17:0] TIMING_ERROR_FLAGS = 18'o500000;

    typedef enum logic [1:0] {
        OP_IOT        = 2'd0,
        OP_TICK       = 2'd1,
        OP_WRITE_FAIL = 2'd2
    } pdc_op_t;

    typedef enum logic [1:0] {
        DEV_DIA_DBA = 2'd0,
        DEV_DWC_DRA = 2'd1,
        DEV_DCL_DSS = 2'd2
    } pdc_device_t;

    localparam logic [1:0] DONE_KEEP  = 2'd0;
    localparam logic [1:0] DONE_CLEAR = 2'd1;
    localparam logic [1:0] DONE_SET   = 2'd2;

    localparam logic [1:0] MULTI_KEEP    = 2'd0;
    localparam logic [1:0] MULTI_DISABLE = 2'd1;
    localparam logic [1:0] MULTI_ENABLE  = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  device;
        logic        sub_select;
        logic [17:0] io_in;
        logic        channel_busy;
    } pdc_item_t;

    typedef struct packed {
        logic [17:0]        io_out;
        logic               io_load;
        logic [1:0]         done_action;
        logic               break_request;
        logic [3:0]         break_channel;
        logic [1:0]         multi_level_action;
        logic               transfer_start;
        logic [1:0]         transfer_mode;
        logic [15:0]        transfer_core_address;
        logic [9:0]         transfer_fields;
        logic [11:0]        transfer_drum_address;
        logic [COUNT_W-1:0] transfer_length;
    } pdc_result_t;

endpackage

// ===== src/parallel_drum_controller_core.sv =====
// ----------------------------------------------------------------------------
// parallel_drum_controller_core: drum controller with IOT access decode
// Path: an accepted item word is held in the item register, and its result
// word is presented from the result register; a result stall can hold it.
// Throughput: one item word per cycle while the result side keeps up; the
// single decode and update stage between the two registers sets this figure.
// Reset: rst_n clears all controller state at once; no clearing pass.
// ----------------------------------------------------------------------------
module parallel_drum_controller_core (
    input  logic                       clk,
    input  logic                       rst_n,
    // Item channel.
    input  logic                       item_valid,
    output logic                       item_stall,
    input  pdc_pkg::pdc_item_t         item,
    // Result channel.
    output logic                       result_valid,
    input  logic                       result_stall,
    output pdc_pkg::pdc_result_t       result,
    // Configuration port.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pdc_pkg::ADDR_W-1:0] paddr,
    input  logic [pdc_pkg::DATA_W-1:0] pwdata,
    output logic [pdc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import pdc_pkg::*;

    // ------------------------------------------------------------------
    // Pipeline control.
    // The item register holds one accepted word. It moves into the result
    // register whenever that register is empty or is being drained in the
    // same cycle, so a new word is taken every cycle while the result side
    // keeps up. When the result side stalls, the item register stays full
    // and the item channel stalls with it.
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    pdc_item_t   s1_item_reg;
    logic        result_valid_reg;
    pdc_result_t result_reg;
    logic        advance;

    assign advance    = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !advance;

    // ------------------------------------------------------------------
    // Controller state.
    // ------------------------------------------------------------------
    logic [15:0]        ticks_per_word_reg;
    logic [15:0]        tick_divider_reg,      tick_divider_next;
    logic [POS_W-1:0]   drum_position_reg,     drum_position_next;
    logic               read_enable_reg,       read_enable_next;
    logic               write_enable_reg,      write_enable_next;
    logic [4:0]         read_field_reg,        read_field_next;
    logic [4:0]         write_field_reg,       write_field_next;
    logic [11:0]        start_address_reg,     start_address_next;
    logic [COUNT_W-1:0] word_count_reg,        word_count_next;
    logic [3:0]         core_bank_reg,         core_bank_next;
    logic [11:0]        core_address_reg,      core_address_next;
    logic               transfer_busy_reg,     transfer_busy_next;
    logic               break_pending_reg,     break_pending_next;
    logic [WAIT_W-1:0]  words_remaining_reg,   words_remaining_next;
    logic               timing_error_reg,      timing_error_next;
    logic [3:0]         interrupt_channel_reg, interrupt_channel_next;

    pdc_result_t        result_next;

    // Helpers for the tick and transfer start paths.
    logic [16:0]        divider_sum;
    logic               word_advanced;
    logic [POS_W-1:0]   target_word;
    logic [POS_W-1:0]   latency;

    // The break and latency both use the drum address reduced to the track.
    assign target_word = start_address_reg[POS_W-1:0];
    // Forward rotational distance from the current position to the target.
    assign latency     = target_word - drum_position_reg;

    // ------------------------------------------------------------------
    // Configuration port. Every access completes in its access cycle.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr == REG_TICKS_PER_WORD)
        begin
            prdata = DATA_W'(ticks_per_word_reg);
        end
    end

    // ------------------------------------------------------------------
    // Decode and update. Everything one item does to the state and to its
    // result word is worked out here in a single pass.
    // ------------------------------------------------------------------
    always_comb
    begin
        tick_divider_next      = tick_divider_reg;
        drum_position_next     = drum_position_reg;
        read_enable_next       = read_enable_reg;
        write_enable_next      = write_enable_reg;
        read_field_next        = read_field_reg;
        write_field_next       = write_field_reg;
        start_address_next     = start_address_reg;
        word_count_next        = word_count_reg;
        core_bank_next         = core_bank_reg;
        core_address_next      = core_address_reg;
        transfer_busy_next     = transfer_busy_reg;
        break_pending_next     = break_pending_reg;
        words_remaining_next   = words_remaining_reg;
        timing_error_next      = timing_error_reg;
        interrupt_channel_next = interrupt_channel_reg;
        result_next            = '0;
        divider_sum            = {1'b0, tick_divider_reg} + 17'd1;
        word_advanced          = 1'b0;

        case (s1_item_reg.op)
            OP_IOT:
            begin
                case (s1_item_reg.device)
                    DEV_DIA_DBA:
                    begin
                        // Load the drum address and read setup. This also
                        // aborts a running transfer and arms or disarms the
                        // break, depending on the variant.
                        result_next.done_action = DONE_CLEAR;
                        transfer_busy_next      = 1'b0;
                        read_enable_next        = s1_item_reg.io_in[17];
                        write_enable_next       = 1'b0;
                        start_address_next      = s1_item_reg.io_in[11:0];
                        read_field_next         = s1_item_reg.io_in[16:12];
                        break_pending_next      = s1_item_reg.sub_select;
                    end
                    DEV_DWC_DRA:
                    begin
                        if (s1_item_reg.sub_select)
                        begin
                            // Position readout, with the error flags folded
                            // in once and then cleared.
                            result_next.io_out  = 18'(drum_position_reg);
                            result_next.io_load = 1'b1;
                            if (timing_error_reg)
                            begin
                                result_next.io_out = 18'(drum_position_reg)
                                                   | TIMING_ERROR_FLAGS;
                                timing_error_next  = 1'b0;
                            end
                        end
                        else
                        begin
                            // Write setup and word count; a zero count
                            // stands for the whole track.
                            write_enable_next = s1_item_reg.io_in[17];
                            write_field_next  = s1_item_reg.io_in[16:12];
                            word_count_next   = {1'b0, s1_item_reg.io_in[11:0]};
                            if (s1_item_reg.io_in[11:0] == 12'd0)
                            begin
                                word_count_next = COUNT_W'(TRACK_WORDS);
                            end
                        end
                    end
                    DEV_DCL_DSS:
                    begin
                        if (s1_item_reg.sub_select)
                        begin
                            // Interrupt mode and channel change.
                            result_next.multi_level_action =
                                s1_item_reg.io_in[5] ? MULTI_ENABLE : MULTI_DISABLE;
                            if (s1_item_reg.io_in[4])
                            begin
                                result_next.io_out     = 18'(interrupt_channel_reg);
                                result_next.io_load    = 1'b1;
                                interrupt_channel_next = s1_item_reg.io_in[3:0];
                            end
                        end
                        else
                        begin
                            // Core address load, and a transfer start when
                            // either direction is enabled. A whole-track
                            // transfer can begin anywhere, so it waits for
                            // no rotational latency.
                            core_bank_next    = s1_item_reg.io_in[15:12];
                            core_address_next = s1_item_reg.io_in[11:0];
                            if (read_enable_reg || write_enable_reg)
                            begin
                                words_remaining_next = word_count_reg;
                                if (word_count_reg != COUNT_W'(TRACK_WORDS))
                                begin
                                    words_remaining_next = word_count_reg
                                                         + WAIT_W'(latency);
                                end
                                transfer_busy_next = 1'b1;
                                break_pending_next = 1'b0;
                                result_next.transfer_start = 1'b1;
                                result_next.transfer_mode  =
                                    {write_enable_reg, read_enable_reg};
                                result_next.transfer_core_address =
                                    {s1_item_reg.io_in[15:12], s1_item_reg.io_in[11:0]};
                                result_next.transfer_fields =
                                    {read_field_reg, write_field_reg};
                                result_next.transfer_drum_address = start_address_reg;
                                result_next.transfer_length       = word_count_reg;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_TICK:
            begin
                // Word timing. A zero setting behaves like one, since the
                // incremented divider always reaches it.
                tick_divider_next = divider_sum[15:0];
                if (divider_sum >= {1'b0, ticks_per_word_reg})
                begin
                    tick_divider_next  = 16'd0;
                    drum_position_next = drum_position_reg + POS_W'(1);
                    word_advanced      = 1'b1;
                end
                if (transfer_busy_reg)
                begin
                    if (word_advanced && words_remaining_reg != '0)
                    begin
                        words_remaining_next = words_remaining_reg - WAIT_W'(1);
                    end
                    if (words_remaining_next == '0 && !s1_item_reg.channel_busy)
                    begin
                        transfer_busy_next      = 1'b0;
                        result_next.done_action = DONE_SET;
                    end
                end
                // The break compares against the position after this tick.
                if (break_pending_reg && drum_position_next == target_word)
                begin
                    break_pending_next          = 1'b0;
                    result_next.break_request   = 1'b1;
                end
            end
            OP_WRITE_FAIL:
            begin
                timing_error_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        result_next.break_channel = interrupt_channel_next;
    end

    // ------------------------------------------------------------------
    // Control and state registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            result_valid_reg      <= 1'b0;
            ticks_per_word_reg    <= TICKS_RESET;
            tick_divider_reg      <= '0;
            drum_position_reg     <= '0;
            read_enable_reg       <= 1'b0;
            write_enable_reg      <= 1'b0;
            read_field_reg        <= '0;
            write_field_reg       <= '0;
            start_address_reg     <= '0;
            word_count_reg        <= COUNT_RESET;
            core_bank_reg         <= '0;
            core_address_reg      <= '0;
            transfer_busy_reg     <= 1'b0;
            break_pending_reg     <= 1'b0;
            words_remaining_reg   <= '0;
            timing_error_reg      <= 1'b0;
            interrupt_channel_reg <= CHANNEL_RESET;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_TICKS_PER_WORD)
            begin
                ticks_per_word_reg <= pwdata[15:0];
            end

            if (!item_stall)
            begin
                s1_valid_reg <= item_valid;
            end

            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                tick_divider_reg      <= tick_divider_next;
                drum_position_reg     <= drum_position_next;
                read_enable_reg       <= read_enable_next;
                write_enable_reg      <= write_enable_next;
                read_field_reg        <= read_field_next;
                write_field_reg       <= write_field_next;
                start_address_reg     <= start_address_next;
                word_count_reg        <= word_count_next;
                core_bank_reg         <= core_bank_next;
                core_address_reg      <= core_address_next;
                transfer_busy_reg     <= transfer_busy_next;
                break_pending_reg     <= break_pending_next;
                words_remaining_reg   <= words_remaining_next;
                timing_error_reg      <= timing_error_next;
                interrupt_channel_reg <= interrupt_channel_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (!item_stall && item_valid)
        begin
            s1_item_reg <= item;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    // The item channel only stalls while a word waits in the item register.
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg)
        else $error("item stall without a held word");

    // A completed transfer leaves the controller idle.
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result_next.done_action == DONE_SET) |=> !transfer_busy_reg)
        else $error("done set while transfer still busy");

    // A break fires once and disarms.
    a_break_disarms: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result_next.break_request) |=> !break_pending_reg)
        else $error("break still pending after firing");

    // A started transfer always has a direction enabled.
    a_start_has_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.transfer_start) |-> result_reg.transfer_mode != 2'd0)
        else $error("transfer started with no direction");
`endif

endmodule

// ===== bench/drum_result_checker.sv =====
// ----------------------------------------------------------------------------
// drum_result_checker: result predictor and comparator for the drum controller
// Follows every accepted item word and configuration write with its own copy
// of the controller state, queues the expected result word and compares each
// accepted result word field by field against the oldest one in the queue.
// ----------------------------------------------------------------------------
module drum_result_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    input  logic                       item_stall,
    input  pdc_pkg::pdc_item_t         item,
    input  logic                       result_valid,
    input  logic                       result_stall,
    input  pdc_pkg::pdc_result_t       result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic                       pready,
    input  logic [pdc_pkg::ADDR_W-1:0] paddr,
    input  logic [pdc_pkg::DATA_W-1:0] pwdata,
    output int                         mismatches,
    output int                         awaited
);
    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;

    // Mirrored controller state.
    int unsigned        tick_limit;
    int unsigned        div_cnt;
    logic [POS_W-1:0]   drum_word;
    logic               rd_en;
    logic               wr_en;
    logic [4:0]         rd_fld;
    logic [4:0]         wr_fld;
    logic [POS_W-1:0]   drum_addr;
    logic [COUNT_W-1:0] xfer_count;
    logic [3:0]         bank;
    logic [11:0]        core_addr;
    logic               busy;
    logic               brk_armed;
    logic [WAIT_W-1:0]  wait_words;
    logic               err_flag;
    logic [3:0]         int_chan;

    pdc_result_t due_results[$];
    int          fail_tally;

    assign mismatches = fail_tally;

    function automatic void clear_state();
        tick_limit = TICKS_RESET;
        div_cnt    = 0;
        drum_word  = '0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        rd_fld     = '0;
        wr_fld     = '0;
        drum_addr  = '0;
        xfer_count = COUNT_RESET;
        bank       = '0;
        core_addr  = '0;
        busy       = 1'b0;
        brk_armed  = 1'b0;
        wait_words = '0;
        err_flag   = 1'b0;
        int_chan   = CHANNEL_RESET;
    endfunction

    // Applies one item word to the mirrored state and returns the result word
    // the controller must produce for it.
    function automatic pdc_result_t drum_step(input pdc_item_t w);
        pdc_result_t      r;
        logic             advanced;
        logic [POS_W-1:0] gap;
        r = '0;
        if (w.op == OP_IOT)
        begin
            if (w.device == DEV_DIA_DBA)
            begin
                r.done_action = DONE_CLEAR;
                busy      = 1'b0;
                rd_en     = w.io_in[17];
                wr_en     = 1'b0;
                drum_addr = w.io_in[11:0];
                rd_fld    = w.io_in[16:12];
                brk_armed = w.sub_select;
            end
            else if (w.device == DEV_DWC_DRA)
            begin
                if (w.sub_select)
                begin
                    r.io_out = {6'd0, drum_word};
                    if (err_flag)
                    begin
                        r.io_out = r.io_out | TIMING_ERROR_FLAGS;
                        err_flag = 1'b0;
                    end
                    r.io_load = 1'b1;
                end
                else
                begin
                    wr_en  = w.io_in[17];
                    wr_fld = w.io_in[16:12];
                    xfer_count = (w.io_in[11:0] == 12'd0) ? COUNT_RESET
                                                          : COUNT_W'(w.io_in[11:0]);
                end
            end
            else if (w.device == DEV_DCL_DSS)
            begin
                if (w.sub_select)
                begin
                    r.multi_level_action = w.io_in[5] ? MULTI_ENABLE : MULTI_DISABLE;
                    if (w.io_in[4])
                    begin
                        r.io_out  = {14'd0, int_chan};
                        r.io_load = 1'b1;
                        int_chan  = w.io_in[3:0];
                    end
                end
                else
                begin
                    bank      = w.io_in[15:12];
                    core_addr = w.io_in[11:0];
                    if (rd_en || wr_en)
                    begin
                        // Whole-track transfers start wherever the drum is.
                        wait_words = WAIT_W'(xfer_count);
                        if (xfer_count != COUNT_RESET)
                        begin
                            gap = drum_addr - drum_word;
                            wait_words = wait_words + WAIT_W'(gap);
                        end
                        busy      = 1'b1;
                        brk_armed = 1'b0;
                        r.transfer_start        = 1'b1;
                        r.transfer_mode         = {wr_en, rd_en};
                        r.transfer_core_address = {bank, core_addr};
                        r.transfer_fields       = {rd_fld, wr_fld};
                        r.transfer_drum_address = drum_addr;
                        r.transfer_length       = xfer_count;
                    end
                end
            end
        end
        else if (w.op == OP_TICK)
        begin
            advanced = 1'b0;
            div_cnt++;
            if (div_cnt >= tick_limit)
            begin
                div_cnt   = 0;
                drum_word = drum_word + 1'b1;
                advanced  = 1'b1;
            end
            if (busy)
            begin
                if (advanced && wait_words != '0)
                    wait_words = wait_words - 1'b1;
                if (wait_words == '0 && !w.channel_busy)
                begin
                    busy = 1'b0;
                    r.done_action = DONE_SET;
                end
            end
            if (brk_armed && drum_word == drum_addr)
            begin
                brk_armed = 1'b0;
                r.break_request = 1'b1;
            end
        end
        else if (w.op == OP_WRITE_FAIL)
        begin
            err_flag = 1'b1;
        end
        r.break_channel = int_chan;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            fail_tally++;
            if (fail_tally <= 50)
                $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pdc_result_t want;
        if (!rst_n)
        begin
            clear_state();
            due_results.delete();
            fail_tally = 0;
            awaited <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_TICKS_PER_WORD)
                tick_limit = pwdata[15:0];
            if (result_valid && !result_stall)
            begin
                if (due_results.size() == 0)
                begin
                    fail_tally++;
                    $error("result word accepted with no expectation waiting");
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("io_out", want.io_out, result.io_out);
                    check_field("io_load", want.io_load, result.io_load);
                    check_field("done_action", want.done_action, result.done_action);
                    check_field("break_request", want.break_request, result.break_request);
                    check_field("break_channel", want.break_channel, result.break_channel);
                    check_field("multi_level_action", want.multi_level_action,
                                result.multi_level_action);
                    check_field("transfer_start", want.transfer_start,
                                result.transfer_start);
                    check_field("transfer_mode", want.transfer_mode, result.transfer_mode);
                    check_field("transfer_core_address", want.transfer_core_address,
                                result.transfer_core_address);
                    check_field("transfer_fields", want.transfer_fields,
                                result.transfer_fields);
                    check_field("transfer_drum_address", want.transfer_drum_address,
                                result.transfer_drum_address);
                    check_field("transfer_length", want.transfer_length,
                                result.transfer_length);
                end
            end
            if (item_valid && !item_stall)
                due_results.push_back(drum_step(item));
            awaited <= due_results.size();
        end
    end

endmodule

// ===== bench/tb_parallel_drum_controller_core.sv =====
// ----------------------------------------------------------------------------
// tb_parallel_drum_controller_core: stimulus and verdict for the drum controller
// Drives a directed opening, then phases of random transfer, break, status and
// noise words under several drum word times, with random item gaps and result
// stalls. The checker beside the controller does all the comparing.
// ----------------------------------------------------------------------------
module tb_parallel_drum_controller_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pdc_pkg::*;

    // Codes the controller decodes as nothing at all.
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] DEV_UNUSED = 2'd3;

    // Cycles without any accepted word before the run is declared hung. The
    // longest correct quiet stretch is a long sender gap plus a long stall plus
    // a configuration write.
    localparam int unsigned HANG_LIMIT = 2000;

    // Words of random stimulus per drum word time setting.
    localparam int unsigned PHASE_WORDS = 220;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    pdc_item_t             item;
    logic                  result_valid;
    logic                  result_stall;
    pdc_result_t           result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    int                    mismatches;
    int                    awaited;

    // The stimulus keeps a rough idea of where the drum is, so that it can aim
    // transfers and breaks a few words ahead and actually see them finish.
    int unsigned           tick_setting = TICKS_RESET;
    int unsigned           tick_phase = 0;
    logic [POS_W-1:0]      drum_guess = '0;
    int unsigned           words_sent = 0;
    logic                  steady = 1'b0;

    parallel_drum_controller_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    drum_result_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .awaited      (awaited)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short idle stretches, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 75)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic pdc_item_t make_word(input logic [1:0] op, input logic [1:0] dev,
                                            input logic sub, input logic [17:0] io,
                                            input logic busy);
        pdc_item_t w;
        w.op           = op;
        w.device       = dev;
        w.sub_select   = sub;
        w.io_in        = io;
        w.channel_busy = busy;
        return w;
    endfunction

    task automatic idle_gap(input int unsigned cycles);
        item_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Presents one item word and holds it until the controller takes it.
    // Afterwards the drum estimate follows any tick, and a random gap may
    // follow unless the current stretch runs without idling.
    task automatic put_word(input pdc_item_t w);
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (w.op == OP_TICK)
        begin
            tick_phase++;
            if (tick_phase >= tick_setting)
            begin
                tick_phase = 0;
                drum_guess = drum_guess + 1'b1;
            end
        end
        // Words the controller ignores do not count toward the stimulus size.
        if (!(w.op == OP_UNUSED || (w.op == OP_IOT && w.device == DEV_UNUSED)))
            words_sent++;
        if (!steady && $urandom_range(0, 99) < 25)
            idle_gap(pick_gap());
    endtask

    // Stops sending and waits until every expected result word has arrived.
    // The counter from the checker is registered, hence the first edge.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    // Writes the drum word time through the configuration port while the
    // controller is idle. The extra cycles are margin after the last result.
    task automatic set_ticks_per_word(input int unsigned ticks);
        drain_results();
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TICKS_PER_WORD;
        pwdata  <= DATA_W'(ticks);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tick_setting = ticks;
    endtask

    task automatic put_tick();
        // The channel is busy now and then, which holds off completion.
        put_word(make_word(OP_TICK, 2'($urandom), 1'($urandom), 18'($urandom),
                           1'($urandom_range(0, 99) < 15)));
    endtask

    // A position read, an interrupt channel change or a write failure report.
    task automatic put_status_word();
        int unsigned kind;
        kind = $urandom_range(0, 2);
        if (kind == 0)
            put_word(make_word(OP_IOT, DEV_DWC_DRA, 1'b1, 18'($urandom), 1'($urandom)));
        else if (kind == 1)
            put_word(make_word(OP_IOT, DEV_DCL_DSS, 1'b1,
                               {12'($urandom), 1'($urandom),
                                1'($urandom_range(0, 9) < 7), 4'($urandom)},
                               1'($urandom)));
        else
            put_word(make_word(OP_WRITE_FAIL, 2'($urandom), 1'($urandom), 18'($urandom),
                               1'($urandom)));
    endtask

    // Ticks enough to cover the given number of drum words, but never an
    // endless run when the word time is long.
    task automatic tick_for(input int unsigned drum_words);
        int unsigned eff;
        int unsigned need;
        eff  = (tick_setting == 0) ? 1 : tick_setting;
        need = drum_words * eff;
        if (need > 64)
            need = $urandom_range(8, 64);
        repeat (need)
        begin
            if ($urandom_range(0, 9) == 0)
                put_status_word();
            else
                put_tick();
        end
    endtask

    // A well-formed transfer: drum address a few words ahead, a short word
    // count, core address and start, then ticks until it should be done.
    task automatic run_transfer();
        int unsigned      ahead;
        int unsigned      count;
        logic [POS_W-1:0] addr;
        ahead = $urandom_range(0, 4);
        count = 8;
        addr  = ($urandom_range(0, 9) == 0) ? POS_W'($urandom) : drum_guess + POS_W'(ahead);
        put_word(make_word(OP_IOT, DEV_DIA_DBA, 1'($urandom),
                           {1'($urandom_range(0, 9) < 8), 5'($urandom), addr},
                           1'($urandom)));
        if ($urandom_range(0, 99) < 85)
        begin
            // A zero count asks for the whole track.
            count = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
            put_word(make_word(OP_IOT, DEV_DWC_DRA, 1'b0,
                               {1'($urandom), 5'($urandom), 12'(count)}, 1'($urandom)));
        end
        if ($urandom_range(0, 4) == 0)
            put_status_word();
        put_word(make_word(OP_IOT, DEV_DCL_DSS, 1'b0, 18'($urandom), 1'($urandom)));
        tick_for(ahead + count + 2);
    endtask

    // Arms a break a few words ahead and lets the drum turn past it.
    task automatic run_break_watch();
        int unsigned ahead;
        ahead = $urandom_range(0, 3);
        put_word(make_word(OP_IOT, DEV_DIA_DBA, 1'b1,
                           {1'($urandom), 5'($urandom), drum_guess + POS_W'(ahead)},
                           1'($urandom)));
        tick_for(ahead + 2);
    endtask

    // Anything at all, unused codes included.
    task automatic run_noise();
        repeat ($urandom_range(1, 4))
            put_word(make_word(2'($urandom), 2'($urandom), 1'($urandom), 18'($urandom),
                               1'($urandom)));
    endtask

    // Opening words at the reset word time: field extremes, every access,
    // the error flag in a position read, channel changes, a transfer with
    // nothing enabled and the unused codes.
    task automatic run_directed();
        put_word(make_word(OP_IOT, DEV_DWC_DRA, 1'b1, 18'd0, 1'b0));
        put_word(make_word(OP_WRITE_FAIL, DEV_DIA_DBA, 1'b0, 18'd0, 1'b0));
        put_word(make_word(OP_IOT, DEV_DWC_DRA, 1'b1, 18'o777777, 1'b1));
        put_word(make_word(OP_IOT, DEV_DWC_DRA, 1'b1, 18'd0, 1'b0));
        put_word(make_word(OP_IOT, DEV_DCL_DSS, 1'b1, 18'd0, 1'b0));
        put_word(make_word(OP_IOT, DEV_DCL_DSS, 1'b1, 18'o000077, 1'b0));
        put_word(make_word(OP_IOT, DEV_DCL_DSS, 1'b1, 18'o000020, 1'b0));
        put_word(make_word(OP_IOT, DEV_DCL_DSS, 1'b1, 18'o777777, 1'b1));
        put_word(make_word(OP_IOT, DEV_DIA_DBA, 1'b0, 18'o777777, 1'b1));
        put_word(make_word(OP_IOT, DEV_DWC_DRA, 1'b0, 18'o777777, 1'b1));
        // A zero word count stands for the whole track.
        put_word(make_word(OP_IOT, DEV_DWC_DRA, 1'b0, 18'd0, 1'b0));
        put_word(make_word(OP_IOT, DEV_DCL_DSS, 1'b0, 18'd0, 1'b0));
        put_tick();
        // Break armed at word zero while the transfer is aborted.
        put_word(make_word(OP_IOT, DEV_DIA_DBA, 1'b1, 18'd0, 1'b0));
        put_word(make_word(OP_TICK, DEV_DIA_DBA, 1'b0, 18'd0, 1'b1));
        // Nothing enabled: the core address loads and no transfer starts.
        put_word(make_word(OP_IOT, DEV_DCL_DSS, 1'b0, 18'o777777, 1'b1));
        put_word(make_word(OP_UNUSED, DEV_UNUSED, 1'b1, 18'o777777, 1'b1));
        put_word(make_word(OP_IOT, DEV_UNUSED, 1'b1, 18'o777777, 1'b1));
        // Write-only transfer of one word.
        put_word(make_word(OP_IOT, DEV_DWC_DRA, 1'b0, 18'o400001, 1'b0));
        put_word(make_word(OP_IOT, DEV_DCL_DSS, 1'b0, 18'o177777, 1'b0));
        put_word(make_word(OP_TICK, DEV_DCL_DSS, 1'b1, 18'o777777, 1'b0));
        put_word(make_word(OP_WRITE_FAIL, DEV_UNUSED, 1'b1, 18'o777777, 1'b1));
        put_word(make_word(OP_IOT, DEV_DWC_DRA, 1'b1, 18'd0, 1'b0));
    endtask

    // Result side: free runs of random length between stalls, with the odd
    // long free run so that some stretches see no stalls at all.
    initial
    begin
        result_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 99) < 85)
                repeat ($urandom_range(1, 10)) @(posedge clk);
            else
                repeat ($urandom_range(60, 300)) @(posedge clk);
            result_stall <= 1'b1;
            repeat (pick_gap()) @(posedge clk);
            result_stall <= 1'b0;
        end
    end

    // Hang detection: counts edges at which neither channel moves a word.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int unsigned phase_ticks[7];
        int unsigned goal;
        int unsigned halfway;
        int unsigned roll;
        logic        held;
        // Drum word times visited in turn: the fastest, zero (which behaves
        // as one), short ones, the longest and the reset value.
        phase_ticks = '{1, 0, 3, 65535, 2, 85, 1};

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        foreach (phase_ticks[p])
        begin
            set_ticks_per_word(phase_ticks[p]);
            goal    = words_sent + PHASE_WORDS;
            halfway = words_sent + PHASE_WORDS / 2;
            held    = 1'b0;
            while (words_sent < goal)
            begin
                // Once per phase the sender holds off until the controller
                // has delivered everything, then carries on.
                if (!held && words_sent >= halfway)
                begin
                    drain_results();
                    held = 1'b1;
                end
                steady = ($urandom_range(0, 6) == 0);
                roll   = $urandom_range(0, 99);
                if (roll < 40)
                    run_transfer();
                else if (roll < 55)
                    run_break_watch();
                else if (roll < 70)
                    put_status_word();
                else
                    run_noise();
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
